// ===== hdl/ptns_pkg.sv =====
`default_nettype none
package ptns_pkg;

    localparam int unsigned DEPTH_DEF = 1024;

    localparam int COORD_W  = 24;
    localparam int PT_W     = 16;
    localparam int DIFF_W   = 25;
    localparam int DIST_W   = 50;
    localparam int INDEX_W  = 10;
    localparam int HITS_W   = 11;
    localparam int FUNC_W   = 3;
    localparam int STATUS_W = 2;

    localparam logic [FUNC_W-1:0] FUNC_ADD     = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_NEAREST = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_COUNT   = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_MATCH   = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR   = 3'd4;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NONE  = 2'd2;

    // one unit in Q16.8
    localparam logic [DIFF_W-1:0] UNIT = 25'd256;

    typedef enum logic [2:0] {
        OP_ADD,
        OP_NEAREST,
        OP_COUNT,
        OP_MATCH,
        OP_CLEAR,
        OP_NOP
    } op_t;

    typedef struct packed {
        op_t                       op;
        logic signed [COORD_W-1:0] x_a;
        logic signed [COORD_W-1:0] y_a;
        logic signed [COORD_W-1:0] x_b;
        logic signed [COORD_W-1:0] y_b;
    } req_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN
    } state_t;

    // round half up to a whole number, saturate at the top
    function automatic logic signed [PT_W-1:0] round_coord(input logic signed [COORD_W-1:0] q);
        logic signed [DIFF_W-1:0] s;
        logic signed [PT_W:0]     r;
        s = {q[COORD_W-1], q} + 25'sd128;
        r = s[DIFF_W-1:8];
        if (r > 17'sd32767)
        begin
            r = 17'sd32767;
        end
        return r[PT_W-1:0];
    endfunction

    // |p*256 - q|
    function automatic logic [DIFF_W-1:0] abs_diff(input logic signed [PT_W-1:0] p,
                                                   input logic signed [COORD_W-1:0] q);
        logic signed [DIFF_W-1:0] d;
        d = {p[PT_W-1], p, 8'h00} - {q[COORD_W-1], q};
        return d[DIFF_W-1] ? (-d) : d;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/ptns_ram.sv =====
`default_nettype none
module ptns_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// ===== hdl/ptns_front.sv =====
`default_nettype none
module ptns_front
    import ptns_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [4*COORD_W-1:0] s_tdata,
    input  wire logic [FUNC_W-1:0]   s_tuser,
    output req_t                     req,
    output logic                     req_valid,
    input  wire logic                req_pop
);

    req_t       entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;
    logic       push;
    req_t       incoming;

    always_comb
    begin
        incoming.x_a = s_tdata[COORD_W-1:0];
        incoming.y_a = s_tdata[2*COORD_W-1:COORD_W];
        incoming.x_b = s_tdata[3*COORD_W-1:2*COORD_W];
        incoming.y_b = s_tdata[4*COORD_W-1:3*COORD_W];
        case (s_tuser)
            FUNC_ADD:     incoming.op = OP_ADD;
            FUNC_NEAREST: incoming.op = OP_NEAREST;
            FUNC_COUNT:   incoming.op = OP_COUNT;
            FUNC_MATCH:   incoming.op = OP_MATCH;
            FUNC_CLEAR:   incoming.op = OP_CLEAR;
            default:      incoming.op = OP_NOP;
        endcase
    end

    assign s_tready  = (fill_reg != 2'd2);
    assign push      = s_tvalid && s_tready;
    assign req_valid = (fill_reg != 2'd0);
    assign req       = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = req_pop ? !rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + {1'b0, push} - {1'b0, req_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= incoming;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/ptns_back.sv =====
`default_nettype none
module ptns_back
    import ptns_pkg::*;
#(
    parameter int unsigned DEPTH = DEPTH_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire req_t             req,
    input  wire logic             req_valid,
    output logic                  req_pop,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [INDEX_W-1:0]    out_index,
    output logic [DIST_W-1:0]     out_dist,
    output logic [HITS_W-1:0]     out_hits,
    output logic [STATUS_W-1:0]   out_status
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    state_t state_reg, state_next;
    op_t    op_reg, op_next;
    req_t   query_reg, query_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [IDX_W-1:0] scan_idx_reg, scan_idx_next;

    // scan pipeline: read, diff, square, accumulate
    logic             v1_reg, v1_next;
    logic [IDX_W-1:0] idx1_reg;
    logic             v2_reg;
    logic [IDX_W-1:0] idx2_reg;
    logic [DIFF_W-1:0] adx2_reg, ady2_reg;
    logic             box2_reg, near2_reg;
    logic             v3_reg;
    logic [IDX_W-1:0] idx3_reg;
    logic [DIST_W-1:0] sqx3_reg, sqy3_reg;
    logic             box3_reg, near3_reg;

    logic             found_reg, found_next;
    logic [DIST_W-1:0] best_reg, best_next;
    logic [IDX_W-1:0] best_idx_reg, best_idx_next;
    logic [CNT_W-1:0] hit_reg, hit_next;

    logic                out_valid_reg, out_valid_next;
    logic [INDEX_W-1:0]  out_index_reg, out_index_next;
    logic [DIST_W-1:0]   out_dist_reg, out_dist_next;
    logic [HITS_W-1:0]   out_hits_reg, out_hits_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic                out_load;

    logic                ram_we;
    logic [2*PT_W-1:0]   ram_rdata;
    logic signed [PT_W-1:0] rd_x, rd_y;
    logic signed [DIFF_W-1:0] px_s, py_s;
    logic [DIFF_W-1:0]   adx1, ady1;
    logic                box1;
    logic [DIST_W-1:0]   sum3;
    logic [CNT_W-1:0]    cnt_inc;

    ptns_ram #(
        .WIDTH (2*PT_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (cnt_reg[IDX_W-1:0]),
        .wdata ({round_coord(req.x_a), round_coord(req.y_a)}),
        .raddr (scan_idx_reg),
        .rdata (ram_rdata)
    );

    // fit index and count into the widths of the result fields
    function automatic logic [INDEX_W-1:0] to_index(input logic [IDX_W-1:0] v);
        logic [IDX_W+INDEX_W-1:0] w;
        w = {{INDEX_W{1'b0}}, v};
        return w[INDEX_W-1:0];
    endfunction

    function automatic logic [HITS_W-1:0] to_hits(input logic [CNT_W-1:0] v);
        logic [CNT_W+HITS_W-1:0] w;
        w = {{HITS_W{1'b0}}, v};
        return w[HITS_W-1:0];
    endfunction

    // stage 1 logic on the read data
    always_comb
    begin
        rd_x = ram_rdata[2*PT_W-1:PT_W];
        rd_y = ram_rdata[PT_W-1:0];
        adx1 = abs_diff(rd_x, query_reg.x_a);
        ady1 = abs_diff(rd_y, query_reg.y_a);
        px_s = {rd_x[PT_W-1], rd_x, 8'h00};
        py_s = {rd_y[PT_W-1], rd_y, 8'h00};
        box1 = (px_s >= $signed({query_reg.x_a[COORD_W-1], query_reg.x_a}))
            && (px_s <= $signed({query_reg.x_b[COORD_W-1], query_reg.x_b}))
            && (py_s >= $signed({query_reg.y_a[COORD_W-1], query_reg.y_a}))
            && (py_s <= $signed({query_reg.y_b[COORD_W-1], query_reg.y_b}));
    end

    assign sum3    = sqx3_reg + sqy3_reg;
    assign cnt_inc = cnt_reg + 1'b1;

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        query_next      = query_reg;
        cnt_next        = cnt_reg;
        scan_idx_next   = scan_idx_reg;
        v1_next         = 1'b0;
        found_next      = found_reg;
        best_next       = best_reg;
        best_idx_next   = best_idx_reg;
        hit_next        = hit_reg;
        req_pop         = 1'b0;
        ram_we          = 1'b0;
        out_load        = 1'b0;
        out_index_next  = '0;
        out_dist_next   = '0;
        out_hits_next   = to_hits(cnt_reg);
        out_status_next = STATUS_OK;

        // accumulate stage
        if (v3_reg)
        begin
            case (op_reg)
                OP_NEAREST:
                begin
                    if (!found_reg || (sum3 < best_reg))
                    begin
                        found_next    = 1'b1;
                        best_next     = sum3;
                        best_idx_next = idx3_reg;
                    end
                end
                OP_COUNT:
                begin
                    if (box3_reg)
                    begin
                        hit_next = hit_reg + 1'b1;
                    end
                end
                OP_MATCH:
                begin
                    if (near3_reg && !found_reg)
                    begin
                        found_next    = 1'b1;
                        best_idx_next = idx3_reg;
                    end
                end
                default:
                begin
                end
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid && !out_valid_reg)
                begin
                    req_pop = 1'b1;
                    case (req.op)
                        OP_ADD:
                        begin
                            out_load = 1'b1;
                            if (cnt_reg == FULL_CNT)
                            begin
                                out_status_next = STATUS_FULL;
                            end
                            else
                            begin
                                ram_we         = 1'b1;
                                cnt_next       = cnt_inc;
                                out_index_next = to_index(cnt_reg[IDX_W-1:0]);
                                out_hits_next  = to_hits(cnt_inc);
                            end
                        end
                        OP_NEAREST, OP_COUNT, OP_MATCH:
                        begin
                            if (cnt_reg == '0)
                            begin
                                out_load = 1'b1;
                                if (req.op == OP_COUNT)
                                begin
                                    out_hits_next = '0;
                                end
                                else
                                begin
                                    out_status_next = STATUS_NONE;
                                end
                            end
                            else
                            begin
                                state_next    = ST_SCAN;
                                op_next       = req.op;
                                query_next    = req;
                                scan_idx_next = '0;
                                found_next    = 1'b0;
                                best_next     = '0;
                                best_idx_next = '0;
                                hit_next      = '0;
                            end
                        end
                        OP_CLEAR:
                        begin
                            out_load      = 1'b1;
                            cnt_next      = '0;
                            out_hits_next = '0;
                        end
                        default:
                        begin
                            out_load = 1'b1;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                v1_next = 1'b1;
                if (CNT_W'(scan_idx_reg) == cnt_reg - 1'b1)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                if (!v1_reg && !v2_reg && !v3_reg)
                begin
                    state_next = ST_IDLE;
                    out_load   = 1'b1;
                    case (op_reg)
                        OP_NEAREST:
                        begin
                            out_index_next = to_index(best_idx_reg);
                            out_dist_next  = best_reg;
                        end
                        OP_COUNT:
                        begin
                            out_hits_next = to_hits(hit_reg);
                        end
                        default:
                        begin
                            if (found_reg)
                            begin
                                out_index_next = to_index(best_idx_reg);
                            end
                            else
                            begin
                                out_status_next = STATUS_NONE;
                            end
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && !out_ready;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            v1_reg        <= v1_next;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        query_reg    <= query_next;
        scan_idx_reg <= scan_idx_next;
        idx1_reg     <= scan_idx_reg;
        idx2_reg     <= idx1_reg;
        adx2_reg     <= adx1;
        ady2_reg     <= ady1;
        box2_reg     <= box1;
        near2_reg    <= (adx1 < UNIT) && (ady1 < UNIT);
        idx3_reg     <= idx2_reg;
        sqx3_reg     <= adx2_reg * adx2_reg;
        sqy3_reg     <= ady2_reg * ady2_reg;
        box3_reg     <= box2_reg;
        near3_reg    <= near2_reg;
        best_reg     <= best_next;
        best_idx_reg <= best_idx_next;
        hit_reg      <= hit_next;
        if (out_load)
        begin
            out_index_reg  <= out_index_next;
            out_dist_reg   <= out_dist_next;
            out_hits_reg   <= out_hits_next;
            out_status_reg <= out_status_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_index  = out_index_reg;
    assign out_dist   = out_dist_reg;
    assign out_hits   = out_hits_reg;
    assign out_status = out_status_reg;

endmodule
`default_nettype wire

// ===== hdl/point_table_nearest_search.sv =====
// Brute-force 2D point table with nearest, box-count and match searches.
// Requests arrive on s_axis: tuser carries the operation code (add, nearest,
// count in box, match within one unit, clear), tdata the Q16.8 coordinates.
// Each request yields exactly one response on m_axis: index, squared
// distance (Q.16), hit count and a status code in tuser.
// Requests enter a two-entry queue; the execution side takes one at a time.
// Add, clear and unused codes have their response registered in the cycle after
// the execution side picks them up. Nearest, count and match read every stored point
// through the single read port of the point memory, one point per cycle, and respond
// once the read, diff, square and accumulate pipeline has drained.
// The next request is started only once the previous response has left
// the output register; while m_axis_tready is low the response holds and
// up to two further requests are still taken into the queue.
// Reset empties the table and the queue; point memory contents are left
// as they are and are never read before being written.
`default_nettype none
module point_table_nearest_search
    import ptns_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = DEPTH_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [95:0] s_axis_tdata,   // x_a[23:0], y_a[47:24], x_b[71:48], y_b[95:72]
    input  wire logic [2:0]  s_axis_tuser,   // func[2:0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [71:0]      m_axis_tdata,   // index[9:0], dist_sq[59:10], hits[70:60], zero
    output logic [1:0]       m_axis_tuser    // status[1:0]
);

    req_t                req;
    logic                req_valid;
    logic                req_pop;
    logic [INDEX_W-1:0]  out_index;
    logic [DIST_W-1:0]   out_dist;
    logic [HITS_W-1:0]   out_hits;

    ptns_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_axis_tvalid),
        .s_tready  (s_axis_tready),
        .s_tdata   (s_axis_tdata),
        .s_tuser   (s_axis_tuser),
        .req       (req),
        .req_valid (req_valid),
        .req_pop   (req_pop)
    );

    ptns_back #(
        .DEPTH (TABLE_DEPTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .req_valid  (req_valid),
        .req_pop    (req_pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_index  (out_index),
        .out_dist   (out_dist),
        .out_hits   (out_hits),
        .out_status (m_axis_tuser)
    );

    assign m_axis_tdata = {1'b0, out_hits, out_dist, out_index};

endmodule
`default_nettype wire
